// ===== design/mee_pkg.sv =====
package mee_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITER = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS   = 4'd1;

    localparam logic [15:0] MAX_ITER_RESET = 16'd1000;
    localparam logic [14:0] RADIUS_RESET   = 15'd15000;

    // fixed point layout
    localparam int POINT_W   = 32;
    localparam int Z_W       = 64;
    localparam int FRAC_BITS = 28;
    localparam int HALF_W    = 22;
    localparam int PP_W      = 2 * HALF_W;
    localparam int SQ_W      = 4 * HALF_W;

    // shade = (255 * count) / 33, the division done by reciprocal
    localparam int          SHADE_W     = 8;
    localparam int          RECIP_SHIFT = 31;
    localparam logic [25:0] RECIP_33    = 26'd65075263;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_MUL,
        ST_SUM,
        ST_TEST,
        ST_SHADE,
        ST_RECIP,
        ST_FIN
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mag;
        logic mul;
        logic sum;
        logic step;
        logic shade;
        logic recip;
        logic out_load;
    } cmd_t;

endpackage

// ===== design/mandelbrot_escape_time.sv =====
// escape-time unit: one point in, one word out, one point in flight at a time
// each iteration passes through the magnitude, partial product, sum and test stages
// after the last test the shade and reciprocal steps run, then the output word register loads
// a new point is taken only once the last word is loaded, which waits while the output is stalled
// reset: synchronous active-low aresetn clears the controller and output valid,
// and sets max_iterations to 1000 and escape_radius to 15000
module mandelbrot_escape_time #(
    parameter int COUNT_BITS = 17
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // c_re [31:0], c_im [63:32]
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [63:0]                           s_tdata,
    // red_shade [7:0], iter_count [COUNT_BITS+7:8], below_limit [COUNT_BITS+8], zero fill
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((COUNT_BITS + 16) / 8) * 8 - 1:0] m_tdata,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mee_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [mee_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import mee_pkg::*;

    localparam int OUT_W   = ((COUNT_BITS + 16) / 8) * 8;

    cmd_t                  cmd;
    logic                  cont;
    logic [SHADE_W-1:0]    red_shade;
    logic [COUNT_BITS-1:0] iter_count;
    logic                  below_limit;

    assign cfg_ready = 1'b1;

    mee_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cont     (cont),
        .cmd      (cmd)
    );

    mee_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .c_re        (s_tdata[POINT_W-1:0]),
        .c_im        (s_tdata[2*POINT_W-1:POINT_W]),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cont        (cont),
        .red_shade   (red_shade),
        .iter_count  (iter_count),
        .below_limit (below_limit)
    );

    // pack result word, lowest field first
    assign m_tdata = OUT_W'({below_limit, iter_count, red_shade});

endmodule

// ===== design/mee_ctrl.sv =====
module mee_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  logic          cont,
    output mee_pkg::cmd_t cmd
);
    import mee_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MAG;
                end
            end
            ST_MAG: begin
                cmd.mag    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                cmd.step   = 1'b1;
                state_next = cont ? ST_MAG : ST_SHADE;
            end
            ST_SHADE: begin
                cmd.shade  = 1'b1;
                state_next = ST_RECIP;
            end
            ST_RECIP: begin
                cmd.recip  = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

// ===== design/mee_datapath.sv =====
module mee_datapath #(
    parameter int COUNT_BITS = 17
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mee_pkg::cmd_t                    cmd,
    input  logic [mee_pkg::POINT_W-1:0]      c_re,
    input  logic [mee_pkg::POINT_W-1:0]      c_im,
    input  logic                             cfg_we,
    input  logic [mee_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mee_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             cont,
    output logic [mee_pkg::SHADE_W-1:0]      red_shade,
    output logic [COUNT_BITS-1:0]            iter_count,
    output logic                             below_limit
);
    import mee_pkg::*;

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // configuration
    logic [15:0] max_iter_reg;
    logic [14:0] radius_reg;
    logic [29:0] rsq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= MAX_ITER_RESET;
            radius_reg   <= RADIUS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MAX_ITER: max_iter_reg <= cfg_data;
                CFG_RADIUS:   radius_reg   <= cfg_data[14:0];
                default:      ;
            endcase
        end
    end

    // squared radius follows the register
    always_ff @(posedge aclk) begin
        rsq_reg <= radius_reg * radius_reg;
    end

    logic [Z_W-1:0]     bound;
    assign bound = Z_W'(radius_reg) << FRAC_BITS;

    // working point and counter
    logic [POINT_W-1:0]    c_re_reg, c_im_reg;
    logic [Z_W-1:0]        z_re_reg, z_im_reg, z_re_next, z_im_next;
    logic [COUNT_BITS-1:0] count_reg;

    // magnitude stage
    logic [Z_W-1:0] mag_re_next, mag_im_next, mag_re_reg, mag_im_reg;
    logic           neg_reg, over_reg;

    assign mag_re_next = z_re_reg[Z_W-1] ? (Z_W'(0) - z_re_reg) : z_re_reg;
    assign mag_im_next = z_im_reg[Z_W-1] ? (Z_W'(0) - z_im_reg) : z_im_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mag) begin
            mag_re_reg <= mag_re_next;
            mag_im_reg <= mag_im_next;
            neg_reg    <= z_re_reg[Z_W-1] ^ z_im_reg[Z_W-1];
            over_reg   <= (mag_re_next > bound) || (mag_im_next > bound);
        end
    end

    // partial products on 22-bit halves
    logic [HALF_W-1:0] a_lo, a_hi, b_lo, b_hi;
    logic [PP_W-1:0]   rr_ll, rr_lh, rr_hh, ii_ll, ii_lh, ii_hh;
    logic [PP_W-1:0]   ri_ll, ri_lh, ri_hl, ri_hh;

    assign a_lo = mag_re_reg[HALF_W-1:0];
    assign a_hi = mag_re_reg[PP_W-1:HALF_W];
    assign b_lo = mag_im_reg[HALF_W-1:0];
    assign b_hi = mag_im_reg[PP_W-1:HALF_W];

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            rr_ll <= a_lo * a_lo;
            rr_lh <= a_lo * a_hi;
            rr_hh <= a_hi * a_hi;
            ii_ll <= b_lo * b_lo;
            ii_lh <= b_lo * b_hi;
            ii_hh <= b_hi * b_hi;
            ri_ll <= a_lo * b_lo;
            ri_lh <= a_lo * b_hi;
            ri_hl <= a_hi * b_lo;
            ri_hh <= a_hi * b_hi;
        end
    end

    // exact products
    logic [SQ_W-1:0] sq_re_reg, sq_im_reg, cross_reg;

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            sq_re_reg <= (SQ_W'(rr_hh) << PP_W) + (SQ_W'(rr_lh) << (HALF_W + 1))
                         + SQ_W'(rr_ll);
            sq_im_reg <= (SQ_W'(ii_hh) << PP_W) + (SQ_W'(ii_lh) << (HALF_W + 1))
                         + SQ_W'(ii_ll);
            cross_reg <= (SQ_W'(ri_hh) << PP_W)
                         + ((SQ_W'(ri_lh) + SQ_W'(ri_hl)) << HALF_W) + SQ_W'(ri_ll);
        end
    end

    // escape test against radius squared
    logic [SQ_W:0]   mag_sum, limit;
    logic            in_radius;
    logic [Z_W-1:0]  rr_q, ii_q, twice_ri, c_re_ext, c_im_ext;

    assign mag_sum   = (SQ_W + 1)'(sq_re_reg) + (SQ_W + 1)'(sq_im_reg);
    assign limit     = (SQ_W + 1)'({rsq_reg, {(2 * FRAC_BITS){1'b0}}});
    assign in_radius = !over_reg && (mag_sum <= limit);
    assign cont      = in_radius && (CMP_W'(count_reg) <= CMP_W'(max_iter_reg))
                       && (count_reg != {COUNT_BITS{1'b1}});

    // next z from the truncated products
    assign rr_q     = Z_W'(sq_re_reg[SQ_W-1:FRAC_BITS]);
    assign ii_q     = Z_W'(sq_im_reg[SQ_W-1:FRAC_BITS]);
    assign twice_ri = Z_W'({cross_reg[SQ_W-1:FRAC_BITS], 1'b0});
    assign c_re_ext = {{(Z_W - POINT_W){c_re_reg[POINT_W-1]}}, c_re_reg};
    assign c_im_ext = {{(Z_W - POINT_W){c_im_reg[POINT_W-1]}}, c_im_reg};
    assign z_re_next = rr_q - ii_q + c_re_ext;
    assign z_im_next = (neg_reg ? (Z_W'(0) - twice_ri) : twice_ri) + c_im_ext;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            c_re_reg  <= c_re;
            c_im_reg  <= c_im;
            z_re_reg  <= '0;
            z_im_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.step && cont) begin
            z_re_reg  <= z_re_next;
            z_im_reg  <= z_im_next;
            count_reg <= count_reg + 1'b1;
        end
    end

    // shade: 255 * count, then multiply by reciprocal of 33
    logic [15:0]          count16;
    logic [23:0]          scaled_reg;
    logic                 below_reg;
    logic [49:0]          recip_prod;
    logic [SHADE_W-1:0]   quot_reg;

    assign count16    = 16'(count_reg);
    assign recip_prod = scaled_reg * RECIP_33;

    always_ff @(posedge aclk) begin
        if (cmd.shade) begin
            scaled_reg <= {count16, 8'b0} - {8'b0, count16};
            below_reg  <= CMP_W'(count_reg) < CMP_W'(max_iter_reg);
        end
        if (cmd.recip) begin
            quot_reg <= recip_prod[RECIP_SHIFT +: SHADE_W];
        end
    end

    // output word register
    logic [SHADE_W-1:0]    red_reg;
    logic [COUNT_BITS-1:0] count_out_reg;
    logic                  below_out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            red_reg       <= below_reg ? quot_reg : '0;
            count_out_reg <= count_reg;
            below_out_reg <= below_reg;
        end
    end

    assign red_shade   = red_reg;
    assign iter_count  = count_out_reg;
    assign below_limit = below_out_reg;

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import mee_pkg::*;

    localparam int CNT_W         = 17;
    localparam int M_W           = ((CNT_W + 16) / 8) * 8;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [CNT_W-1:0] CNT_CAP = {CNT_W{1'b1}};
    // index that maps to no register, writes to it must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_NONE = 4'd7;

    // one result word: red_shade, iter_count, below_limit from the lowest bit up
    typedef struct packed {
        logic             below;
        logic [CNT_W-1:0] cnt;
        logic [7:0]       red;
    } result_t;

    // directed row: either a register write or a point, optionally with a known answer
    typedef struct {
        bit                     is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  val;
        logic [31:0]            re;
        logic [31:0]            im;
        bit                     typed;
        logic [7:0]             red;
        logic [CNT_W-1:0]       cnt;
        bit                     below;
    } step_t;

    // random phase: register setting, length and handshake pressure
    typedef struct {
        logic [15:0] max_iter;
        logic [15:0] radius;
        int          len;
        int          idle_pct;
        int          stall_pct;
        bit          pressure;
        bit          draw_cfg;
    } phase_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [63:0]            s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_W-1:0]         m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // register copies for the predictor
    logic [15:0] max_iter_q = MAX_ITER_RESET;
    logic [14:0] radius_q   = RADIUS_RESET;

    result_t pending[$];
    result_t want;
    result_t got;
    int idle_pct  = 0;
    int stall_pct = 0;
    int n_fail    = 0;
    int n_points  = 0;
    int n_writes  = 0;
    int n_escaped = 0;
    int n_capped  = 0;

    mandelbrot_escape_time #(
        .COUNT_BITS(CNT_W)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("[mandelbrot_escape_time] ERROR");
        $finish;
    end

    // Q28 times Q28, magnitude truncated toward zero, sign put back
    function automatic logic signed [63:0] q28_product(logic signed [63:0] a,
                                                       logic signed [63:0] b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        logic [63:0]  r;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        p  = {64'd0, ma} * {64'd0, mb};
        r  = p[91:28];
        return (a[63] ^ b[63]) ? -r : r;
    endfunction

    // exact |z| <= R test, saturating when one part alone is past R
    function automatic bit within_radius(logic signed [63:0] re, logic signed [63:0] im,
                                         logic [14:0] radius);
        logic [63:0]  bound;
        logic [63:0]  ar;
        logic [63:0]  ai;
        logic [127:0] mag2;
        logic [127:0] lim2;
        bound = {49'd0, radius} << FRAC_BITS;
        ar    = re[63] ? -re : re;
        ai    = im[63] ? -im : im;
        if (ar > bound || ai > bound)
            return 1'b0;
        mag2 = {64'd0, ar} * {64'd0, ar} + {64'd0, ai} * {64'd0, ai};
        lim2 = {64'd0, bound} * {64'd0, bound};
        return mag2 <= lim2;
    endfunction

    // escape-time count and shade for one point under the current registers
    function automatic result_t escape_time(logic signed [31:0] cre_in,
                                            logic signed [31:0] cim_in);
        logic signed [63:0] cre;
        logic signed [63:0] cim;
        logic signed [63:0] re;
        logic signed [63:0] im;
        logic signed [63:0] rr;
        logic signed [63:0] ii;
        logic signed [63:0] ri;
        logic [CNT_W-1:0]   count;
        logic [31:0]        shade;
        result_t            res;
        cre   = cre_in;
        cim   = cim_in;
        re    = '0;
        im    = '0;
        count = '0;
        while (within_radius(re, im, radius_q) && count <= {1'b0, max_iter_q}
               && count < CNT_CAP) begin
            rr    = q28_product(re, re);
            ii    = q28_product(im, im);
            ri    = q28_product(re, im);
            re    = rr - ii + cre;
            im    = (ri <<< 1) + cim;
            count = count + 1'b1;
        end
        shade     = (32'd255 * {15'd0, count}) / 32'd33;
        res.cnt   = count;
        res.below = count < {1'b0, max_iter_q};
        res.red   = res.below ? shade[7:0] : 8'd0;
        return res;
    endfunction

    // coordinate mix: mostly near the set, some full range, tiny and edge values
    function automatic logic [31:0] pick_coord();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return $urandom_range(32'h4000_0000) - 32'h2000_0000;
        if (roll < 85)
            return $urandom();
        if (roll < 92)
            return $urandom_range(16) - 32'd8;
        case ($urandom_range(4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hE000_0000;
            default: return 32'h0400_0000;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_MAX_ITER)
            max_iter_q = val;
        else if (idx == CFG_RADIUS)
            radius_q = val[14:0];
        n_writes++;
    endtask

    // offer one point, hold it until taken, then queue its expected word
    task automatic send_point(input logic [31:0] re, input logic [31:0] im,
                              input bit typed, input result_t typed_res);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        do @(posedge aclk); while (!s_tready);
        pending.push_back(typed ? typed_res : escape_time(re, im));
        n_points++;
    endtask

    // stop offering points and let every outstanding word come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[CNT_W+8:0];
            if (got.below)
                n_escaped++;
            else
                n_capped++;
            if (pending.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("result word %h with nothing outstanding", m_tdata);
            end else begin
                want = pending.pop_front();
                if (got.red !== want.red || got.cnt !== want.cnt
                    || got.below !== want.below) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch: red %0d/%0d count %0d/%0d below %0d/%0d (exp/got)",
                                 want.red, got.red, want.cnt, got.cnt,
                                 want.below, got.below);
                end
            end
        end
    end

    initial begin
        step_t  plan[0:24];
        phase_t sched[0:7];
        bit     prev_cfg;
        result_t known;

        plan = '{
            // defaults: origin runs to limit + 1
            '{0, CFG_MAX_ITER, 16'h0, 32'h0000_0000, 32'h0000_0000, 1, 8'd0, 17'd1001, 0},
            '{0, CFG_MAX_ITER, 16'h0, 32'h8000_0000, 32'h0000_0000, 0, 8'd0, 17'd0, 0},
            '{0, CFG_MAX_ITER, 16'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 8'd0, 17'd0, 0},
            '{0, CFG_MAX_ITER, 16'h0, 32'h8000_0000, 32'h8000_0000, 0, 8'd0, 17'd0, 0},
            '{0, CFG_MAX_ITER, 16'h0, 32'h0000_0000, 32'h7FFF_FFFF, 0, 8'd0, 17'd0, 0},
            // limit zero: a single pass, never below the limit
            '{1, CFG_MAX_ITER, 16'h0000, 32'h0, 32'h0, 0, 8'd0, 17'd0, 0},
            '{0, CFG_MAX_ITER, 16'h0, 32'h0000_0000, 32'h0000_0000, 1, 8'd0, 17'd1, 0},
            '{0, CFG_MAX_ITER, 16'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 8'd0, 17'd1, 0},
            // radius zero via a write with bit 15 set: only the origin stays inside
            '{1, CFG_MAX_ITER, 16'd20, 32'h0, 32'h0, 0, 8'd0, 17'd0, 0},
            '{1, CFG_RADIUS, 16'h8000, 32'h0, 32'h0, 0, 8'd0, 17'd0, 0},
            '{0, CFG_MAX_ITER, 16'h0, 32'h0000_0000, 32'h0000_0000, 1, 8'd0, 17'd21, 0},
            '{0, CFG_MAX_ITER, 16'h0, 32'h0000_0001, 32'h0000_0000, 1, 8'd7, 17'd1, 1},
            '{0, CFG_MAX_ITER, 16'h0, 32'h0000_0000, 32'hFFFF_FFFF, 1, 8'd7, 17'd1, 1},
            // unmapped index leaves both registers alone
            '{1, CFG_NONE, 16'h0001, 32'h0, 32'h0, 0, 8'd0, 17'd0, 0},
            '{0, CFG_MAX_ITER, 16'h0, 32'h0000_0000, 32'h0000_0000, 1, 8'd0, 17'd21, 0},
            // both registers at their top: origin drives the count to 65536
            '{1, CFG_MAX_ITER, 16'hFFFF, 32'h0, 32'h0, 0, 8'd0, 17'd0, 0},
            '{1, CFG_RADIUS, 16'hFFFF, 32'h0, 32'h0, 0, 8'd0, 17'd0, 0},
            '{0, CFG_MAX_ITER, 16'h0, 32'h8000_0000, 32'h8000_0000, 0, 8'd0, 17'd0, 0},
            '{0, CFG_MAX_ITER, 16'h0, 32'h0000_0000, 32'h0000_0000, 1, 8'd0, 17'd65536, 0},
            // small radius: -2 sits exactly on the boundary, +2 leaves quickly
            '{1, CFG_MAX_ITER, 16'd33, 32'h0, 32'h0, 0, 8'd0, 17'd0, 0},
            '{1, CFG_RADIUS, 16'd2, 32'h0, 32'h0, 0, 8'd0, 17'd0, 0},
            '{0, CFG_MAX_ITER, 16'h0, 32'h0400_0000, 32'h0000_0000, 0, 8'd0, 17'd0, 0},
            '{0, CFG_MAX_ITER, 16'h0, 32'hE000_0000, 32'h0000_0000, 0, 8'd0, 17'd0, 0},
            '{0, CFG_MAX_ITER, 16'h0, 32'h2000_0000, 32'h0000_0000, 0, 8'd0, 17'd0, 0},
            '{0, CFG_MAX_ITER, 16'h0, 32'hF400_0000, 32'h0199_999A, 0, 8'd0, 17'd0, 0}
        };

        sched = '{
            '{16'd40,   16'd2,     90, 0,  0,  0, 0},
            '{16'd64,   16'd4,     80, 80, 0,  0, 0},
            '{16'd16,   16'd1,     80, 0,  80, 0, 0},
            '{16'd100,  16'd2,     80, 25, 25, 1, 0},
            '{16'd1000, 16'd15000, 30, 0,  0,  0, 0},
            '{16'd255,  16'd32767, 70, 25, 25, 0, 0},
            '{16'd0,    16'd3,     60, 80, 0,  0, 0},
            '{16'd0,    16'd0,     80, 0,  80, 0, 1}
        };

        // reset
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed walk
        prev_cfg = 1'b0;
        for (int i = 0; i < 25; i++) begin
            if (plan[i].is_cfg) begin
                if (!prev_cfg)
                    drain_results();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                known = '{below: plan[i].below, cnt: plan[i].cnt, red: plan[i].red};
                send_point(plan[i].re, plan[i].im, plan[i].typed, known);
            end
            prev_cfg = plan[i].is_cfg;
        end

        // random phases
        for (int p = 0; p < 8; p++) begin
            drain_results();
            if (sched[p].draw_cfg) begin
                sched[p].max_iter = 16'($urandom_range(1, 60));
                sched[p].radius   = 16'($urandom_range(0, 8));
            end
            write_reg(CFG_MAX_ITER, sched[p].max_iter);
            write_reg(CFG_RADIUS, sched[p].radius);
            idle_pct  = sched[p].idle_pct;
            stall_pct = sched[p].stall_pct;
            for (int k = 0; k < sched[p].len; k++) begin
                send_point(pick_coord(), pick_coord(), 1'b0, '0);
                if (sched[p].pressure && k % 20 == 19)
                    drain_results();
            end
        end

        drain_results();
        cfg_valid <= 1'b0;
        $display("%0d points under %0d register writes: %0d escaped below the limit, %0d hit it",
                 n_points, n_writes, n_escaped, n_capped);
        if (n_fail == 0) begin
            $display("[mandelbrot_escape_time] OK");
        end else begin
            $display("%0d failing result words", n_fail);
            $display("[mandelbrot_escape_time] ERROR");
        end
        $finish;
    end

endmodule
